// File: rtl/core/assert_macros.svh
// Assertion macros used by the allocator datapath (gfba_dp).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define GFBA_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("gfba assertion failed");
`define GFBA_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("gfba forbidden condition");
`else
`define GFBA_ASSERT(lbl, clk, rst, prop)
`define GFBA_NEVER(lbl, clk, rst, expr)
`endif
`endif

// File: rtl/core/gfba_pkg.sv
// Types and constants of the grouped free-block allocator.
package gfba_pkg;

   localparam int STACK_DEPTH = 32;
   localparam int BLOCK_BITS  = 16;
   localparam int FIELD_BITS  = 16;
   localparam int ADDR_BITS   = $clog2(STACK_DEPTH);
   localparam int COUNT_BITS  = $clog2(STACK_DEPTH + 1);

   typedef enum logic [1:0] {
      FUNC_ALLOC   = 2'd0,
      FUNC_RELEASE = 2'd1,
      FUNC_REFILL  = 2'd2
   } func_type;

   typedef enum logic [2:0] {
      KIND_GRANTED    = 3'd0,
      KIND_NO_SPACE   = 3'd1,
      KIND_READ_CHAIN = 3'd2,
      KIND_WRITE_WORD = 3'd3,
      KIND_RELEASED   = 3'd4,
      KIND_REFILL_OK  = 3'd5,
      KIND_REFUSED    = 3'd6
   } kind_type;

   typedef enum logic [1:0] {
      BLK_ZERO = 2'd0,
      BLK_IN   = 2'd1,
      BLK_HELD = 2'd2,
      BLK_RAM  = 2'd3
   } blk_src_type;

   typedef enum logic [1:0] {
      WORD_ZERO  = 2'd0,
      WORD_COUNT = 2'd1,
      WORD_RAM   = 2'd2
   } word_src_type;

   typedef struct packed {
      logic         accept;
      logic         emit;
      kind_type     kind;
      logic         last;
      blk_src_type  blk_src;
      word_src_type word_src;
      logic         rd_spill;
      logic         hold_ram;
      logic         refill_store;
      logic         pop_commit;
      logic         pop_zero;
      logic         start_refill;
      logic         push;
      logic         push_reset;
      logic         idx_inc;
   } gfba_cmd_type;

   typedef struct packed {
      logic out_free;
      logic awaiting;
      logic count_zero;
      logic count_one;
      logic count_full;
      logic ram_zero;
      logic idx_last;
   } gfba_status_type;

endpackage

// File: rtl/core/grouped_free_block_allocator.sv
// Grouped free-block allocator: a free-block stack with chain refill and spill.
// Results are registered; allocate goes through ST_POP, a spilling release through ST_SPILL_HDR.
// One item a cycle while the result is taken; allocate adds ST_POP, and ST_CHAIN when it empties the stack.
// A spill on release streams all STACK_DEPTH stack entries through the single stack RAM read port.
// Synchronous active-high reset empties the stack count and leaves refill mode; no clearing pass.
module grouped_free_block_allocator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // block_number[15:0], refill_word[31:16]
   input  logic [1:0]  req_tuser,  // func[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,  // result_block[15:0], chain_word[31:16]
   output logic [2:0]  rsp_tuser,  // kind[2:0]
   output logic        rsp_tlast
);

   gfba_pkg::gfba_cmd_type    cmd;
   gfba_pkg::gfba_status_type status;
   logic [gfba_pkg::FIELD_BITS-1:0] rsp_block, rsp_word;

   gfba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_func  (req_tuser),
      .status    (status),
      .cmd       (cmd)
   );

   gfba_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_block (req_tdata[15:0]),
      .req_word  (req_tdata[31:16]),
      .rsp_tready(rsp_tready),
      .rsp_valid (rsp_tvalid),
      .rsp_kind  (rsp_tuser),
      .rsp_block (rsp_block),
      .rsp_word  (rsp_word),
      .rsp_last  (rsp_tlast)
   );

   assign rsp_tdata = {rsp_word, rsp_block};

endmodule

// File: rtl/core/gfba_ram.sv
// Generic single-port-write RAM with registered read.
module gfba_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/gfba_ctrl.sv
// Controller state machine of the allocator.
module gfba_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [1:0]               req_func,
   input  gfba_pkg::gfba_status_type status,
   output gfba_pkg::gfba_cmd_type   cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_POP,
      ST_CHAIN,
      ST_SPILL_HDR,
      ST_SPILL_RD,
      ST_SPILL_WR,
      ST_PUSH
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      cmd        = '0;
      state_in   = state_ff;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = status.out_free;
            if (req_tvalid && status.out_free) begin
               cmd.accept = 1'b1;
               cmd.emit   = 1'b1;
               cmd.last   = 1'b1;
               cmd.kind   = gfba_pkg::KIND_REFUSED;
               if (status.awaiting) begin
                  if (gfba_pkg::func_type'(req_func) == gfba_pkg::FUNC_REFILL) begin
                     cmd.refill_store = 1'b1;
                     cmd.kind         = gfba_pkg::KIND_REFILL_OK;
                  end
               end else begin
                  case (gfba_pkg::func_type'(req_func))
                     gfba_pkg::FUNC_ALLOC: begin
                        if (status.count_zero) begin
                           cmd.kind = gfba_pkg::KIND_NO_SPACE;
                        end else begin
                           cmd.emit = 1'b0;
                           state_in = ST_POP;
                        end
                     end
                     gfba_pkg::FUNC_RELEASE: begin
                        if (status.count_full) begin
                           cmd.emit = 1'b0;
                           state_in = ST_SPILL_HDR;
                        end else begin
                           cmd.push    = 1'b1;
                           cmd.blk_src = gfba_pkg::BLK_IN;
                           cmd.kind    = gfba_pkg::KIND_RELEASED;
                        end
                     end
                     default: cmd.kind = gfba_pkg::KIND_REFUSED;
                  endcase
               end
            end
         end
         ST_POP: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
               if (status.ram_zero) begin
                  cmd.pop_zero = 1'b1;
                  cmd.kind     = gfba_pkg::KIND_NO_SPACE;
                  cmd.last     = 1'b1;
               end else if (status.count_one) begin
                  cmd.pop_commit   = 1'b1;
                  cmd.start_refill = 1'b1;
                  cmd.hold_ram     = 1'b1;
                  cmd.blk_src      = gfba_pkg::BLK_RAM;
                  cmd.kind         = gfba_pkg::KIND_READ_CHAIN;
                  state_in         = ST_CHAIN;
               end else begin
                  cmd.pop_commit = 1'b1;
                  cmd.blk_src    = gfba_pkg::BLK_RAM;
                  cmd.kind       = gfba_pkg::KIND_GRANTED;
                  cmd.last       = 1'b1;
               end
            end
         end
         ST_CHAIN: begin
            if (status.out_free) begin
               cmd.emit    = 1'b1;
               cmd.blk_src = gfba_pkg::BLK_HELD;
               cmd.kind    = gfba_pkg::KIND_GRANTED;
               cmd.last    = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         ST_SPILL_HDR: begin
            if (status.out_free) begin
               cmd.emit     = 1'b1;
               cmd.blk_src  = gfba_pkg::BLK_HELD;
               cmd.word_src = gfba_pkg::WORD_COUNT;
               cmd.kind     = gfba_pkg::KIND_WRITE_WORD;
               state_in     = ST_SPILL_RD;
            end
         end
         ST_SPILL_RD: begin
            cmd.rd_spill = 1'b1;
            state_in     = ST_SPILL_WR;
         end
         ST_SPILL_WR: begin
            cmd.rd_spill = 1'b1;
            if (status.out_free) begin
               cmd.emit     = 1'b1;
               cmd.blk_src  = gfba_pkg::BLK_HELD;
               cmd.word_src = gfba_pkg::WORD_RAM;
               cmd.kind     = gfba_pkg::KIND_WRITE_WORD;
               cmd.idx_inc  = 1'b1;
               state_in     = status.idx_last ? ST_PUSH : ST_SPILL_RD;
            end
         end
         ST_PUSH: begin
            if (status.out_free) begin
               cmd.emit       = 1'b1;
               cmd.push       = 1'b1;
               cmd.push_reset = 1'b1;
               cmd.blk_src    = gfba_pkg::BLK_HELD;
               cmd.kind       = gfba_pkg::KIND_RELEASED;
               cmd.last       = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// File: rtl/core/gfba_dp.sv
// Datapath of the allocator: stack RAM, count, refill tracking, result register.
`include "assert_macros.svh"

module gfba_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  gfba_pkg::gfba_cmd_type              cmd,
   output gfba_pkg::gfba_status_type           status,
   input  logic [gfba_pkg::FIELD_BITS-1:0]     req_block,
   input  logic [gfba_pkg::FIELD_BITS-1:0]     req_word,
   input  logic                                rsp_tready,
   output logic                                rsp_valid,
   output logic [2:0]                          rsp_kind,
   output logic [gfba_pkg::FIELD_BITS-1:0]     rsp_block,
   output logic [gfba_pkg::FIELD_BITS-1:0]     rsp_word,
   output logic                                rsp_last
);

   localparam int AW = gfba_pkg::ADDR_BITS;
   localparam int CW = gfba_pkg::COUNT_BITS;
   localparam int BW = gfba_pkg::BLOCK_BITS;
   localparam int FW = gfba_pkg::FIELD_BITS;

   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] pos_ff, pos_in;
   logic          awaiting_ff, awaiting_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic [BW-1:0] blk_ff, blk_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [2:0]    rsp_kind_ff, rsp_kind_in;
   logic [FW-1:0] rsp_block_ff, rsp_block_in;
   logic [FW-1:0] rsp_word_ff, rsp_word_in;
   logic          rsp_last_ff, rsp_last_in;

   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [BW-1:0] wr_data, rd_data, blk_sel, blk_req;
   logic [FW-1:0] word_sel;

   assign blk_req = BW'(req_block);
   assign rd_addr = cmd.rd_spill ? idx_ff : AW'(count_ff - CW'(1));

   gfba_ram #(
      .WIDTH(BW),
      .DEPTH(gfba_pkg::STACK_DEPTH)
   ) u_stack (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   always_comb begin
      case (cmd.blk_src)
         gfba_pkg::BLK_IN:   blk_sel = blk_req;
         gfba_pkg::BLK_HELD: blk_sel = blk_ff;
         gfba_pkg::BLK_RAM:  blk_sel = rd_data;
         default:            blk_sel = '0;
      endcase
      case (cmd.word_src)
         gfba_pkg::WORD_COUNT: word_sel = FW'(count_ff);
         gfba_pkg::WORD_RAM:   word_sel = FW'(rd_data);
         default:              word_sel = '0;
      endcase
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = count_ff[AW-1:0];
      wr_data = blk_sel;
      if (cmd.refill_store && (pos_ff != '0)) begin
         wr_en   = 1'b1;
         wr_addr = AW'(pos_ff - CW'(1));
         wr_data = BW'(req_word);
      end
      if (cmd.push) begin
         wr_en   = 1'b1;
         wr_addr = cmd.push_reset ? '0 : count_ff[AW-1:0];
         wr_data = blk_sel;
      end
   end

   always_comb begin
      count_in    = count_ff;
      pos_in      = pos_ff;
      awaiting_in = awaiting_ff;
      idx_in      = idx_ff;
      blk_in      = blk_ff;
      if (cmd.refill_store) begin
         if (pos_ff == '0) begin
            count_in = (req_word > FW'(gfba_pkg::STACK_DEPTH)) ?
                       CW'(gfba_pkg::STACK_DEPTH) : CW'(req_word);
         end
         if (pos_ff == CW'(gfba_pkg::STACK_DEPTH)) begin
            pos_in      = '0;
            awaiting_in = 1'b0;
         end else begin
            pos_in = pos_ff + CW'(1);
         end
      end
      if (cmd.pop_zero) begin
         count_in = '0;
      end
      if (cmd.pop_commit) begin
         count_in = count_ff - CW'(1);
      end
      if (cmd.start_refill) begin
         awaiting_in = 1'b1;
         pos_in      = '0;
      end
      if (cmd.push) begin
         count_in = cmd.push_reset ? CW'(1) : count_ff + CW'(1);
      end
      if (cmd.accept) begin
         idx_in = '0;
         blk_in = blk_req;
      end
      if (cmd.idx_inc) begin
         idx_in = idx_ff + AW'(1);
      end
      if (cmd.hold_ram) begin
         blk_in = rd_data;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_block_in = rsp_block_ff;
      rsp_word_in  = rsp_word_ff;
      rsp_last_in  = rsp_last_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = cmd.kind;
         rsp_block_in = FW'(blk_sel);
         rsp_word_in  = word_sel;
         rsp_last_in  = cmd.last;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         pos_ff       <= '0;
         awaiting_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         pos_ff       <= pos_in;
         awaiting_ff  <= awaiting_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff       <= idx_in;
      blk_ff       <= blk_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_block_ff <= rsp_block_in;
      rsp_word_ff  <= rsp_word_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign status.out_free   = !rsp_valid_ff || rsp_tready;
   assign status.awaiting   = awaiting_ff;
   assign status.count_zero = (count_ff == '0);
   assign status.count_one  = (count_ff == CW'(1));
   assign status.count_full = (count_ff >= CW'(gfba_pkg::STACK_DEPTH));
   assign status.ram_zero   = (rd_data == '0);
   assign status.idx_last   = (idx_ff == AW'(gfba_pkg::STACK_DEPTH - 1));

   assign rsp_valid = rsp_valid_ff;
   assign rsp_kind  = rsp_kind_ff;
   assign rsp_block = rsp_block_ff;
   assign rsp_word  = rsp_word_ff;
   assign rsp_last  = rsp_last_ff;

   `GFBA_NEVER(a_count_bound, clock, reset, count_ff > CW'(gfba_pkg::STACK_DEPTH))
   `GFBA_ASSERT(a_pos_in_refill, clock, reset, (pos_ff != '0) |-> awaiting_ff)
   `GFBA_NEVER(a_no_overwrite, clock, reset, cmd.emit && rsp_valid_ff && !rsp_tready)
   `GFBA_ASSERT(a_refill_empty, clock, reset, cmd.start_refill |=> (count_ff == '0))

endmodule

// File: tb/grouped_free_block_allocator_test.sv
`timescale 1ns / 1ps
// Self-checking stream testbench for the grouped free-block allocator.
module grouped_free_block_allocator_test;

   localparam int ITEM_TARGET    = 430;
   localparam int QUIET_FROM     = 370;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 100;
   localparam int REPORT_LIMIT   = 10;
   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   typedef struct packed {
      logic [1:0]  func;
      logic [15:0] blk;
      logic [15:0] word;
   } request_item_type;

   typedef struct packed {
      gfba_pkg::kind_type kind;
      logic [15:0]        blk;
      logic [15:0]        word;
      logic               last;
   } response_item_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        rsp_tlast;

   // predicted allocator state
   logic [gfba_pkg::BLOCK_BITS-1:0] free_stack [gfba_pkg::STACK_DEPTH];
   int free_count = 0;
   bit refill_pending = 1'b0;
   int refill_pos = 0;

   request_item_type  pending_items[$];
   response_item_type expected_results[$];

   bit presenting = 1'b0;
   bit quiet = 1'b0;
   int idle_left = 0;
   int stall_left = 0;
   int item_total = 0;
   int results_seen = 0;
   int mismatches = 0;
   int idle_cycles = 0;
   int spill_count = 0;
   int refill_count = 0;

   grouped_free_block_allocator u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   task automatic note_result(input gfba_pkg::kind_type kind, input logic [15:0] blk,
                              input logic [15:0] word, input logic last);
      response_item_type r;
      r.kind = kind;
      r.blk  = blk;
      r.word = word;
      r.last = last;
      expected_results.push_back(r);
   endtask

   task automatic predict_allocator(input request_item_type it);
      logic [gfba_pkg::BLOCK_BITS-1:0] popped;
      if (refill_pending) begin
         if (it.func != gfba_pkg::FUNC_REFILL) begin
            note_result(gfba_pkg::KIND_REFUSED, '0, '0, 1'b1);
         end else begin
            if (refill_pos == 0) begin
               free_count = (it.word > gfba_pkg::STACK_DEPTH) ?
                            gfba_pkg::STACK_DEPTH : int'(it.word);
            end else begin
               free_stack[refill_pos - 1] = it.word[gfba_pkg::BLOCK_BITS-1:0];
            end
            refill_pos++;
            if (refill_pos > gfba_pkg::STACK_DEPTH) begin
               refill_pending = 1'b0;
               refill_pos = 0;
               refill_count++;
            end
            note_result(gfba_pkg::KIND_REFILL_OK, '0, '0, 1'b1);
         end
      end else if (it.func == gfba_pkg::FUNC_ALLOC) begin
         if (free_count == 0) begin
            note_result(gfba_pkg::KIND_NO_SPACE, '0, '0, 1'b1);
         end else begin
            free_count--;
            popped = free_stack[free_count];
            if (popped == '0) begin
               // terminator entry
               free_count = 0;
               note_result(gfba_pkg::KIND_NO_SPACE, '0, '0, 1'b1);
            end else begin
               if (free_count == 0) begin
                  note_result(gfba_pkg::KIND_READ_CHAIN, popped, '0, 1'b0);
                  refill_pending = 1'b1;
                  refill_pos = 0;
               end
               note_result(gfba_pkg::KIND_GRANTED, popped, '0, 1'b1);
            end
         end
      end else if (it.func == gfba_pkg::FUNC_RELEASE) begin
         if (free_count >= gfba_pkg::STACK_DEPTH) begin
            // spill header and whole stack into the released block
            note_result(gfba_pkg::KIND_WRITE_WORD, it.blk, 16'(free_count), 1'b0);
            for (int i = 0; i < gfba_pkg::STACK_DEPTH; i++) begin
               note_result(gfba_pkg::KIND_WRITE_WORD, it.blk, free_stack[i], 1'b0);
            end
            free_count = 0;
            spill_count++;
         end
         free_stack[free_count] = it.blk[gfba_pkg::BLOCK_BITS-1:0];
         free_count++;
         note_result(gfba_pkg::KIND_RELEASED, it.blk, '0, 1'b1);
      end else begin
         note_result(gfba_pkg::KIND_REFUSED, '0, '0, 1'b1);
      end
   endtask

   task automatic add_item(input logic [1:0] func, input logic [15:0] blk,
                           input logic [15:0] word);
      request_item_type it;
      it.func = func;
      it.blk  = blk;
      it.word = word;
      pending_items.push_back(it);
      item_total++;
   endtask

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!presenting) begin
         if (idle_left > 0) begin
            idle_left--;
            req_tvalid <= 1'b0;
         end else if (!quiet && $urandom_range(0, 11) == 0) begin
            idle_left = $urandom_range(0, 10);
            req_tvalid <= 1'b0;
         end else if (pending_items.size() != 0) begin
            req_tvalid <= 1'b1;
            req_tdata  <= {pending_items[0].word, pending_items[0].blk};
            req_tuser  <= pending_items[0].func;
            presenting = 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         predict_allocator(pending_items.pop_front());
         presenting = 1'b0;
      end
   end

   // response back-pressure
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 15) == 0) begin
         stall_left = $urandom_range(0, 10);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // response monitor
   always @(posedge clock) begin : monitor
      response_item_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
               $display("unexpected item: kind %0d block %h word %h last %b",
                        rsp_tuser, rsp_tdata[15:0], rsp_tdata[31:16], rsp_tlast);
            end
         end else begin
            want = expected_results.pop_front();
            if (rsp_tuser !== want.kind || rsp_tdata[15:0] !== want.blk ||
                rsp_tdata[31:16] !== want.word || rsp_tlast !== want.last) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT) begin
                  $display("mismatch: expected kind %0d block %h word %h last %b",
                           want.kind, want.blk, want.word, want.last);
                  $display("          actual   kind %0d block %h word %h last %b",
                           rsp_tuser, rsp_tdata[15:0], rsp_tdata[31:16], rsp_tlast);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired after %0d cycles without progress", idle_cycles);
         $display("FAILED: results differ");
         $finish;
      end
   end

   initial begin : stimulus
      logic [15:0] word;
      int pick;
      bit first_refill;
      first_refill = 1'b1;
      for (int i = 0; i < gfba_pkg::STACK_DEPTH; i++) begin
         free_stack[i] = '0;
      end
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty stack, stray codes, terminator, chain read, refusals
      add_item(gfba_pkg::FUNC_ALLOC, 16'h0000, 16'h0000);
      add_item(gfba_pkg::FUNC_REFILL, 16'h0000, 16'hFFFF);
      add_item(FUNC_UNUSED, 16'hFFFF, 16'hFFFF);
      add_item(gfba_pkg::FUNC_RELEASE, 16'h0000, 16'hFFFF);
      add_item(gfba_pkg::FUNC_RELEASE, 16'hFFFF, 16'h0000);
      add_item(gfba_pkg::FUNC_RELEASE, 16'h5A5A, 16'hA5A5);
      add_item(gfba_pkg::FUNC_ALLOC, 16'hFFFF, 16'hFFFF);
      add_item(gfba_pkg::FUNC_ALLOC, 16'h0000, 16'h0000);
      add_item(gfba_pkg::FUNC_ALLOC, 16'h0000, 16'h0000);
      add_item(gfba_pkg::FUNC_RELEASE, 16'hA5A5, 16'h5A5A);
      add_item(gfba_pkg::FUNC_ALLOC, 16'h0000, 16'h0000);
      add_item(gfba_pkg::FUNC_ALLOC, 16'h0000, 16'h0000);
      add_item(gfba_pkg::FUNC_RELEASE, 16'h1234, 16'h4321);
      add_item(FUNC_UNUSED, 16'h0000, 16'h0000);

      while (item_total < ITEM_TARGET) begin
         while (pending_items.size() != 0 || presenting) @(negedge clock);
         if (refill_pending) begin
            // count word then one word per stack entry, with stray items mixed in
            for (int k = 0; k <= gfba_pkg::STACK_DEPTH; k++) begin
               if ($urandom_range(0, 99) < 8) begin
                  case ($urandom_range(0, 2))
                     0: add_item(gfba_pkg::FUNC_ALLOC, 16'($urandom), 16'($urandom));
                     1: add_item(gfba_pkg::FUNC_RELEASE, 16'($urandom), 16'($urandom));
                     default: add_item(FUNC_UNUSED, 16'($urandom), 16'($urandom));
                  endcase
               end
               if (k == 0) begin
                  if (first_refill) begin
                     word = 16'hFFFF;
                  end else begin
                     case ($urandom_range(0, 9))
                        0, 1, 2, 3: word = 16'(gfba_pkg::STACK_DEPTH);
                        4, 5: word = 16'($urandom_range(0, gfba_pkg::STACK_DEPTH));
                        6, 7: word = 16'($urandom_range(gfba_pkg::STACK_DEPTH + 1, 16'hFFFF));
                        8: word = 16'h0000;
                        default: word = 16'($urandom_range(1, 3));
                     endcase
                  end
                  first_refill = 1'b0;
               end else begin
                  word = ($urandom_range(0, 19) == 0) ? 16'h0000 : 16'($urandom);
               end
               add_item(gfba_pkg::FUNC_REFILL, 16'($urandom), word);
            end
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 12) begin
               repeat ($urandom_range(1, 3)) begin
                  add_item($urandom_range(0, 1) ? gfba_pkg::FUNC_REFILL : FUNC_UNUSED,
                           16'($urandom), 16'($urandom));
               end
            end else if (free_count >= 24 ? pick < 75 : pick < 55) begin
               repeat ($urandom_range(1, 40)) begin
                  add_item(gfba_pkg::FUNC_RELEASE,
                           ($urandom_range(0, 29) == 0) ? 16'h0000 : 16'($urandom),
                           16'($urandom));
               end
            end else begin
               repeat ($urandom_range(1, (free_count < 38) ? free_count + 2 : 40)) begin
                  add_item(gfba_pkg::FUNC_ALLOC, 16'($urandom), 16'($urandom));
               end
            end
         end
         if (item_total >= QUIET_FROM) quiet = 1'b1;
      end

      quiet = 1'b1;
      while (pending_items.size() != 0 || presenting) @(negedge clock);
      while (expected_results.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Run sent %0d items and checked %0d results: %0d stack spills, %0d chain refills.",
               item_total, results_seen, spill_count, refill_count);
      $display("Mismatched or unexpected results: %0d", mismatches);
      if (mismatches == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
